// File: rtl/core/pcpd_pkg.sv
// shared types and register indexes for the pid controller
`default_nettype none

package pcpd_pkg;

    localparam int CFG_DATA_W = 20;
    localparam int CFG_IDX_W  = 3;
    localparam int ERR_W      = 17;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_MODE           = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_P         = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_I         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_D         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INTEGRAL_CLAMP = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUTPUT_CLAMP   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_CUTOFF   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_ZONE      = 3'd7;

    localparam logic MODE_POSITIONAL  = 1'b0;
    localparam logic MODE_INCREMENTAL = 1'b1;

    typedef struct packed {
        logic        mode;
        logic [19:0] gain_p;
        logic [19:0] gain_i;
        logic [19:0] gain_d;
        logic [14:0] integral_clamp;
        logic [14:0] output_clamp;
        logic [15:0] error_cutoff;
        logic [15:0] dead_zone;
    } pcpd_cfg_t;

    // classified item passed from front to back
    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic                    gated;
        logic                    use_i;
    } pcpd_item_t;

endpackage

`default_nettype wire

// File: rtl/core/pcpd_front.sv
// front end: accepts items, forms the error and classifies the tick
`default_nettype none

module pcpd_front (
    input  wire                   s_valid,
    output logic                  s_ready,
    input  wire  signed [15:0]    s_measured,
    input  wire  signed [15:0]    s_target,
    input  pcpd_pkg::pcpd_cfg_t   cfg,
    input  wire                   q_full,
    output logic                  q_push,
    output pcpd_pkg::pcpd_item_t  q_item
);
    import pcpd_pkg::*;

    logic signed [ERR_W-1:0] err;
    logic        [ERR_W-1:0] mag;
    logic        [ERR_W-1:0] dz_sep;
    logic                    over_cutoff;
    logic                    under_dz;
    logic                    separated;

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        err = ERR_W'({s_target[15], s_target}) - ERR_W'({s_measured[15], s_measured});
        mag = err[ERR_W-1] ? ERR_W'(-err) : ERR_W'(err);
        dz_sep = ERR_W'({1'b0, cfg.dead_zone}) + ERR_W'(4);
        over_cutoff = (cfg.error_cutoff != '0) && (mag > ERR_W'({1'b0, cfg.error_cutoff}));
        under_dz    = (cfg.dead_zone != '0) && (mag < ERR_W'({1'b0, cfg.dead_zone}));
        // integral separation only applies in positional mode
        separated   = (cfg.dead_zone != '0) && (mag > dz_sep);
        q_item.err   = err;
        q_item.gated = over_cutoff || under_dz;
        q_item.use_i = (cfg.mode == MODE_INCREMENTAL) || !separated;
    end

endmodule

`default_nettype wire

// File: rtl/core/pcpd_queue.sv
// two-entry queue between front and back
`default_nettype none

module pcpd_queue (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   push,
    input  pcpd_pkg::pcpd_item_t  push_item,
    output logic                  full,
    input  wire                   pop,
    output logic                  not_empty,
    output pcpd_pkg::pcpd_item_t  pop_item
);
    import pcpd_pkg::*;

    pcpd_item_t  entry_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_pop;

    assign full      = (count_reg == 2'd2);
    assign not_empty = (count_reg != 2'd0);
    assign pop_item  = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pcpd_back.sv
// back end: three-stage pid datapath with the controller state
`default_nettype none

module pcpd_back (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  pcpd_pkg::pcpd_cfg_t   cfg,
    input  wire                   q_valid,
    input  pcpd_pkg::pcpd_item_t  q_item,
    output logic                  q_pop,
    output logic                  m_valid,
    input  wire                   m_ready,
    output logic signed [15:0]    m_drive,
    output logic                  m_gated
);
    import pcpd_pkg::*;

    logic en;

    // history and state
    logic signed [ERR_W-1:0] err_prev_reg, err_prev2_reg;
    logic signed [23:0]      isum_reg, isum_next;
    logic signed [15:0]      prev_delta_reg;

    // stage 1: products
    logic signed [19:0] e_x, e1_x, e2_x, diff1, diff2, px, dx;
    logic signed [40:0] prod_p_next, prod_d_next;
    logic signed [37:0] prod_i_next;
    logic               v1_reg, gated1_reg, use_i1_reg;
    logic signed [40:0] prod_p_reg, prod_d_reg;
    logic signed [37:0] prod_i_reg;

    // stage 2: integral and p+d
    logic signed [23:0] ilim;
    logic signed [38:0] acc_raw, ilim_w;
    logic signed [32:0] pterm, dterm;
    logic signed [33:0] psum_next;
    logic signed [15:0] iterm_next;
    logic               v2_reg, gated2_reg;
    logic signed [33:0] psum_reg;
    logic signed [15:0] iterm_reg;

    // stage 3: final sum and output register
    logic signed [34:0] sum_raw, olim_w;
    logic signed [15:0] olim, res_next;
    logic               m_valid_reg;
    logic signed [15:0] m_drive_reg;
    logic               m_gated_reg;

    assign en      = !m_valid_reg || m_ready;
    assign q_pop   = en;
    assign m_valid = m_valid_reg;
    assign m_drive = m_drive_reg;
    assign m_gated = m_gated_reg;

    always_comb begin
        e_x   = 20'(q_item.err);
        e1_x  = 20'(err_prev_reg);
        e2_x  = 20'(err_prev2_reg);
        diff1 = e_x - e1_x;
        diff2 = e_x - (e1_x <<< 1) + e2_x;
        px    = (cfg.mode == MODE_INCREMENTAL) ? diff1 : e_x;
        dx    = (cfg.mode == MODE_INCREMENTAL) ? diff2 : diff1;
        prod_p_next = $signed({1'b0, cfg.gain_p}) * px;
        prod_d_next = $signed({1'b0, cfg.gain_d}) * dx;
        prod_i_next = $signed({1'b0, cfg.gain_i}) * q_item.err;
    end

    always_comb begin
        ilim   = $signed({1'b0, cfg.integral_clamp, 8'd0});
        ilim_w = 39'(ilim);
        acc_raw = (cfg.mode == MODE_INCREMENTAL) ? 39'(prod_i_reg)
                                                  : 39'(isum_reg) + 39'(prod_i_reg);
        if (acc_raw > ilim_w) begin
            isum_next = ilim;
        end else if (acc_raw < -ilim_w) begin
            isum_next = -ilim;
        end else begin
            isum_next = acc_raw[23:0];
        end
        pterm      = 33'(prod_p_reg >>> 8);
        dterm      = 33'(prod_d_reg >>> 8);
        psum_next  = 34'(pterm) + 34'(dterm);
        iterm_next = use_i1_reg ? 16'(isum_next >>> 8) : 16'sd0;
    end

    always_comb begin
        olim    = $signed({1'b0, cfg.output_clamp});
        olim_w  = 35'(olim);
        sum_raw = 35'(psum_reg) + 35'(iterm_reg);
        if (cfg.mode == MODE_INCREMENTAL) begin
            sum_raw = sum_raw + 35'(prev_delta_reg);
        end
        if (sum_raw > olim_w) begin
            res_next = olim;
        end else if (sum_raw < -olim_w) begin
            res_next = -olim;
        end else begin
            res_next = sum_raw[15:0];
        end
    end

    // control and state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg         <= 1'b0;
            v2_reg         <= 1'b0;
            m_valid_reg    <= 1'b0;
            err_prev_reg   <= '0;
            err_prev2_reg  <= '0;
            isum_reg       <= '0;
            prev_delta_reg <= '0;
        end else if (en) begin
            v1_reg      <= q_valid;
            v2_reg      <= v1_reg;
            m_valid_reg <= v2_reg;
            if (q_valid && !q_item.gated) begin
                err_prev2_reg <= err_prev_reg;
                err_prev_reg  <= q_item.err;
            end
            if (v1_reg && !gated1_reg) begin
                isum_reg <= isum_next;
            end
            if (v2_reg && !gated2_reg && (cfg.mode == MODE_INCREMENTAL)) begin
                prev_delta_reg <= res_next;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (en) begin
            gated1_reg  <= q_item.gated;
            use_i1_reg  <= q_item.use_i;
            prod_p_reg  <= prod_p_next;
            prod_d_reg  <= prod_d_next;
            prod_i_reg  <= prod_i_next;
            gated2_reg  <= gated1_reg;
            psum_reg    <= psum_next;
            iterm_reg   <= iterm_next;
            m_gated_reg <= gated2_reg;
            m_drive_reg <= gated2_reg ? 16'sd0 : res_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/pid_controller_pos_delta_unit.sv
// pid controller with positional and incremental modes, top level
// an accepted item passes through a queue entry, the stage 1 and stage 2 registers and the output register
// throughput: one item per cycle; the two-entry queue lets input continue while
// the result side stalls, and the back end advances only when its output register frees
// reset (aresetn, synchronous, active low) clears the queue, pipeline valids,
// error history, integral, incremental output and loads register reset values
`default_nettype none

module pid_controller_pos_delta_unit (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire  [2:0]          cfg_index,
    input  wire  [19:0]         cfg_wdata,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire  signed [15:0]  s_measured,
    input  wire  signed [15:0]  s_target,
    output logic                m_valid,
    input  wire                 m_ready,
    output logic signed [15:0]  m_drive,
    output logic                m_gated
);
    import pcpd_pkg::*;

    pcpd_cfg_t  cfg_reg;
    pcpd_item_t push_item, pop_item;
    logic       q_push, q_full, q_pop, q_valid;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode           <= MODE_POSITIONAL;
            cfg_reg.gain_p         <= '0;
            cfg_reg.gain_i         <= '0;
            cfg_reg.gain_d         <= '0;
            cfg_reg.integral_clamp <= 15'h7fff;
            cfg_reg.output_clamp   <= 15'h7fff;
            cfg_reg.error_cutoff   <= '0;
            cfg_reg.dead_zone      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE: begin
                    cfg_reg.mode <= cfg_wdata[0];
                end
                REG_GAIN_P: begin
                    cfg_reg.gain_p <= cfg_wdata;
                end
                REG_GAIN_I: begin
                    cfg_reg.gain_i <= cfg_wdata;
                end
                REG_GAIN_D: begin
                    cfg_reg.gain_d <= cfg_wdata;
                end
                REG_INTEGRAL_CLAMP: begin
                    cfg_reg.integral_clamp <= cfg_wdata[14:0];
                end
                REG_OUTPUT_CLAMP: begin
                    cfg_reg.output_clamp <= cfg_wdata[14:0];
                end
                REG_ERROR_CUTOFF: begin
                    cfg_reg.error_cutoff <= cfg_wdata[15:0];
                end
                REG_DEAD_ZONE: begin
                    cfg_reg.dead_zone <= cfg_wdata[15:0];
                end
                default: begin
                end
            endcase
        end
    end

    pcpd_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_target   (s_target),
        .cfg        (cfg_reg),
        .q_full     (q_full),
        .q_push     (q_push),
        .q_item     (push_item)
    );

    pcpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_item  (pop_item)
    );

    pcpd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_valid),
        .q_item  (pop_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_drive (m_drive),
        .m_gated (m_gated)
    );

endmodule

`default_nettype wire

// File: bench/pid_tick_pkg.sv
// scoreboard for the pid controller: tick predictor, expected drive queue and compare
`timescale 1ns / 100ps

package pid_tick_pkg;
    import pcpd_pkg::*;

    typedef struct packed {
        logic signed [15:0] drive;
        logic               gated;
    } tick_out_t;

    class pid_tick_board;
        logic   mode;
        longint gain_p, gain_i, gain_d;
        longint int_lim, out_lim, cutoff, dead_zone;
        longint err_prev, err_prev2, integral, incr_last;
        tick_out_t drive_due[$];
        int mismatches;
        int results_seen;
        int gated_seen;

        function new();
            mode      = MODE_POSITIONAL;
            gain_p    = 0;
            gain_i    = 0;
            gain_d    = 0;
            int_lim   = 32767;
            out_lim   = 32767;
            cutoff    = 0;
            dead_zone = 0;
            err_prev  = 0;
            err_prev2 = 0;
            integral  = 0;
            incr_last = 0;
            mismatches   = 0;
            results_seen = 0;
            gated_seen   = 0;
        endfunction

        // bits above the register width are dropped
        function void write_reg(logic [2:0] idx, logic [19:0] data);
            case (idx)
                REG_MODE:           mode      = data[0];
                REG_GAIN_P:         gain_p    = longint'(data);
                REG_GAIN_I:         gain_i    = longint'(data);
                REG_GAIN_D:         gain_d    = longint'(data);
                REG_INTEGRAL_CLAMP: int_lim   = longint'(data[14:0]);
                REG_OUTPUT_CLAMP:   out_lim   = longint'(data[14:0]);
                REG_ERROR_CUTOFF:   cutoff    = longint'(data[15:0]);
                REG_DEAD_ZONE:      dead_zone = longint'(data[15:0]);
                default: ;
            endcase
        endfunction

        function longint sat(longint x, longint lim);
            if (x > lim)
                return lim;
            if (x < -lim)
                return -lim;
            return x;
        endfunction

        function tick_out_t next_drive(logic signed [15:0] meas, logic signed [15:0] tgt);
            longint    e, mag, p, d, acc, sum;
            bit        use_i;
            tick_out_t r;
            e   = longint'(tgt) - longint'(meas);
            mag = (e < 0) ? -e : e;
            // gated tick leaves history and integral alone
            if ((cutoff != 0 && mag > cutoff) || (dead_zone != 0 && mag < dead_zone)) begin
                r.drive = '0;
                r.gated = 1'b1;
                return r;
            end
            if (mode == MODE_POSITIONAL) begin
                // integral separation: still accumulated, left out of the sum
                use_i    = !(dead_zone != 0 && mag > dead_zone + 4);
                p        = (gain_p * e) >>> 8;
                d        = (gain_d * (e - err_prev)) >>> 8;
                acc      = sat(integral + gain_i * e, int_lim * 256);
                integral = acc;
                sum      = sat(p + d + (use_i ? (acc >>> 8) : 64'sd0), out_lim);
            end else begin
                p         = (gain_p * (e - err_prev)) >>> 8;
                d         = (gain_d * (e - 2 * err_prev + err_prev2)) >>> 8;
                acc       = sat(gain_i * e, int_lim * 256);
                integral  = acc;
                sum       = sat(incr_last + p + (acc >>> 8) + d, out_lim);
                incr_last = sum;
            end
            err_prev2 = err_prev;
            err_prev  = e;
            r.drive   = sum[15:0];
            r.gated   = 1'b0;
            return r;
        endfunction

        function void note_input(logic signed [15:0] meas, logic signed [15:0] tgt);
            drive_due.push_back(next_drive(meas, tgt));
        endfunction

        function void check_result(logic signed [15:0] drive, logic gated);
            tick_out_t want;
            if (drive_due.size() == 0) begin
                $error("result with no item outstanding: drive %0d gated %0b", drive, gated);
                mismatches++;
                return;
            end
            want = drive_due.pop_front();
            results_seen++;
            if (want.gated)
                gated_seen++;
            if (drive !== want.drive) begin
                $error("drive mismatch: expected %0d, actual %0d", want.drive, drive);
                mismatches++;
            end
            if (gated !== want.gated) begin
                $error("gated mismatch: expected %0b, actual %0b", want.gated, gated);
                mismatches++;
            end
        endfunction

        function int pending();
            return drive_due.size();
        endfunction
    endclass

endpackage

// File: bench/tb_top.sv
// top level bench for the pid controller: clock, reset, drivers, monitor and phases
`timescale 1ns / 100ps

module tb_top;
    import pcpd_pkg::*;
    import pid_tick_pkg::*;

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [19:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic signed [15:0] s_measured = '0;
    logic signed [15:0] s_target = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [15:0] m_drive;
    logic               m_gated;

    pid_tick_board board;
    int hold_len = 0;
    int burst_left = 1;
    int items_in = 0;
    int phases = 0;
    int delta_phases = 0;

    pid_controller_pos_delta_unit dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_measured (s_measured),
        .s_target   (s_target),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_drive    (m_drive),
        .m_gated    (m_gated)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                board.note_input(s_measured, s_target);
                items_in++;
            end
            if (m_valid && m_ready)
                board.check_result(m_drive, m_gated);
        end
    end

    // result side: a new stall style is picked after each random span, long hold-off on request
    initial begin
        int style;
        int span;
        @(posedge aresetn);
        forever begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(5, 60);
            repeat (span) begin
                @(negedge aclk);
                if (hold_len > 0) begin
                    m_ready = 1'b0;
                    repeat (hold_len) @(negedge aclk);
                    hold_len = 0;
                end
                case (style)
                    0: begin
                        m_ready = 1'b1;
                    end
                    1: begin
                        m_ready = 1'($urandom_range(0, 1));
                    end
                    2: begin
                        m_ready = ($urandom_range(0, 3) == 0);
                    end
                    default: begin
                        m_ready = ~m_ready;
                    end
                endcase
            end
        end
    end

    initial begin
        #3_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pcpd_cfg_t make_cfg(logic md, logic [19:0] gp, logic [19:0] gi,
                                           logic [19:0] gd, logic [14:0] ic, logic [14:0] oc,
                                           logic [15:0] co, logic [15:0] dz);
        pcpd_cfg_t c;
        c.mode           = md;
        c.gain_p         = gp;
        c.gain_i         = gi;
        c.gain_d         = gd;
        c.integral_clamp = ic;
        c.output_clamp   = oc;
        c.error_cutoff   = co;
        c.dead_zone      = dz;
        return c;
    endfunction

    function automatic logic [19:0] pick_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 20'hFFFFF;
            2, 3: return 20'($urandom_range(0, 1023));
            4: return 20'($urandom_range(0, 65535));
            default: return 20'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] pick_clamp();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return 15'h7FFF;
            2, 3: return 15'($urandom_range(1, 2000));
            default: return 15'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic pcpd_cfg_t random_cfg();
        pcpd_cfg_t c;
        c.mode           = 1'($urandom_range(0, 1));
        c.gain_p         = pick_gain();
        c.gain_i         = pick_gain();
        c.gain_d         = pick_gain();
        c.integral_clamp = pick_clamp();
        c.output_clamp   = pick_clamp();
        case ($urandom_range(0, 5))
            0, 1, 2: c.error_cutoff = '0;
            3: c.error_cutoff = 16'hFFFF;
            4: c.error_cutoff = 16'($urandom_range(50, 8000));
            default: c.error_cutoff = 16'($urandom_range(1, 65535));
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: c.dead_zone = '0;
            5: c.dead_zone = 16'hFFFF;
            6: c.dead_zone = 16'($urandom_range(1, 65535));
            default: c.dead_zone = 16'($urandom_range(1, 400));
        endcase
        return c;
    endfunction

    // caller makes sure nothing is outstanding; unused upper data bits carry noise
    task automatic set_config(input pcpd_cfg_t c);
        logic [19:0] vals [8];
        int          widths [8];
        logic [19:0] keep;
        vals[REG_MODE]             = 20'(c.mode);
        vals[REG_GAIN_P]           = c.gain_p;
        vals[REG_GAIN_I]           = c.gain_i;
        vals[REG_GAIN_D]           = c.gain_d;
        vals[REG_INTEGRAL_CLAMP]   = 20'(c.integral_clamp);
        vals[REG_OUTPUT_CLAMP]     = 20'(c.output_clamp);
        vals[REG_ERROR_CUTOFF]     = 20'(c.error_cutoff);
        vals[REG_DEAD_ZONE]        = 20'(c.dead_zone);
        widths[REG_MODE]           = 1;
        widths[REG_GAIN_P]         = 20;
        widths[REG_GAIN_I]         = 20;
        widths[REG_GAIN_D]         = 20;
        widths[REG_INTEGRAL_CLAMP] = 15;
        widths[REG_OUTPUT_CLAMP]   = 15;
        widths[REG_ERROR_CUTOFF]   = 16;
        widths[REG_DEAD_ZONE]      = 16;
        for (int i = 0; i < 8; i++) begin
            keep      = (20'h1 << widths[i]) - 20'h1;
            if (widths[i] == 20)
                keep = 20'hFFFFF;
            cfg_wr_en = 1'b1;
            cfg_index = 3'(i);
            cfg_wdata = (20'($urandom) & ~keep) | (vals[i] & keep);
            board.write_reg(cfg_index, cfg_wdata);
            @(negedge aclk);
        end
        cfg_wr_en = 1'b0;
        phases++;
        if (c.mode == MODE_INCREMENTAL)
            delta_phases++;
    endtask

    task automatic offer(input logic signed [15:0] meas, input logic signed [15:0] tgt);
        s_measured = meas;
        s_target   = tgt;
        s_valid    = 1'b1;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    task automatic pause_sender(input int cycles);
        s_valid    = 1'b0;
        s_measured = 16'($urandom);
        s_target   = 16'($urandom);
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic push_item(input logic signed [15:0] meas, input logic signed [15:0] tgt);
        offer(meas, tgt);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            pause_sender(($urandom_range(0, 15) == 0) ? $urandom_range(20, 60)
                                                       : $urandom_range(1, 10));
        end
    endtask

    // error e placed around a mid value so both fields stay in range
    task automatic push_err(input int e);
        int tv;
        int mv;
        tv = 1000 + e / 2;
        mv = tv - e;
        push_item(16'(mv), 16'(tv));
    endtask

    task automatic drain();
        s_valid = 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    // mostly a loop settling near its setpoint, with wide errors and rail values mixed in
    task automatic random_item(output logic signed [15:0] meas, output logic signed [15:0] tgt);
        int tv;
        int mv;
        int kind;
        kind = $urandom_range(0, 9);
        tv   = int'($urandom_range(0, 65535)) - 32768;
        if (kind < 5)
            mv = tv + int'($urandom_range(0, 600)) - 300;
        else if (kind < 7)
            mv = tv + int'($urandom_range(0, 10000)) - 5000;
        else if (kind < 9)
            mv = int'($urandom_range(0, 65535)) - 32768;
        else begin
            tv = $urandom_range(0, 1) ? 32767 : -32768;
            mv = $urandom_range(0, 1) ? 32767 : -32768;
        end
        if (mv > 32767)
            mv = 32767;
        if (mv < -32768)
            mv = -32768;
        meas = 16'(mv);
        tgt  = 16'(tv);
    endtask

    initial begin
        logic signed [15:0] meas;
        logic signed [15:0] tgt;
        pcpd_cfg_t          c;
        int                 count;
        board = new();
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset values: all gains zero
        push_item(-16'sd32768, 16'sd32767);
        push_item(16'sd1234, -16'sd77);
        drain();

        // full gains, full clamps, rails of the error
        set_config(make_cfg(MODE_POSITIONAL, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                            15'h7FFF, 15'h7FFF, 16'h0000, 16'h0000));
        push_item(-16'sd32768, 16'sd32767);
        push_item(16'sd32767, -16'sd32768);
        push_item(16'sd0, 16'sd0);
        push_item(-16'sd1, -16'sd1);
        drain();

        // cutoff and dead zone gating, edges of both, integral separation
        set_config(make_cfg(MODE_POSITIONAL, 20'h00180, 20'h00040, 20'h00100,
                            15'd200, 15'd3000, 16'd1000, 16'd100));
        push_err(50);
        push_err(2000);
        push_err(-1500);
        push_err(102);
        push_err(104);
        push_err(105);
        push_err(-300);
        push_err(1000);
        push_err(100);
        drain();

        // incremental mode, then positional carrying the overwritten integral
        set_config(make_cfg(MODE_INCREMENTAL, 20'h00200, 20'h00080, 20'h00040,
                            15'd50, 15'd20000, 16'h0000, 16'h0000));
        push_err(10);
        push_err(500);
        push_err(-800);
        push_item(-16'sd32768, 16'sd32767);
        push_item(16'sd32767, -16'sd32768);
        drain();
        set_config(make_cfg(MODE_POSITIONAL, 20'h00200, 20'h00080, 20'h00040,
                            15'd50, 15'd20000, 16'h0000, 16'h0000));
        push_err(30);
        drain();
        // zero clamps force everything to zero
        set_config(make_cfg(MODE_POSITIONAL, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                            15'd0, 15'd0, 16'h0000, 16'h0000));
        push_err(-4000);
        push_err(4000);
        drain();

        for (int ph = 0; ph < 12; ph++) begin
            if (ph == 0)
                c = make_cfg(MODE_INCREMENTAL, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF,
                             15'h7FFF, 15'h7FFF, 16'h0000, 16'h0000);
            else if (ph == 1)
                c = make_cfg(MODE_POSITIONAL, 20'h00100, 20'h00010, 20'h00080,
                             15'd500, 15'h7FFF, 16'h0000, 16'd20);
            else
                c = random_cfg();
            set_config(c);
            count = 0;
            while (count < 110) begin
                if (count == 20 && (ph % 4) == 2)
                    hold_len = $urandom_range(150, 300);
                if (count == 70 && (ph % 3) == 1)
                    drain();
                random_item(meas, tgt);
                push_item(meas, tgt);
                count++;
            end
            drain();
        end

        drain();
        repeat (10) @(negedge aclk);
        $display("covered %0d items over %0d register settings, %0d of them incremental",
                 items_in, phases, delta_phases);
        $display("%0d results compared, %0d of them gated", board.results_seen,
                 board.gated_seen);
        if (board.mismatches == 0 && board.pending() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
